>>> rtl/core/pbts_pkg.sv
`default_nettype none
package pbts_pkg;
    localparam int PEERS = 8;
    localparam int ENTRIES = 64;
    localparam int LOCAL_BUNDLES = 256;
    localparam int PEER_W = 3;
    localparam int SLOT_W = 6;
    localparam int CNT_W = 7;
    localparam int LADDR_W = 8;
    localparam int LCNT_W = 9;
    localparam int KEY_W = 64;
    localparam int VER_W = 63;
    localparam int SIZE_W = 8;
    localparam logic [15:0] SEED_RESET = 16'd44257;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    typedef enum logic [1:0] {
        CMD_NOTE_PEER  = 2'd0,
        CMD_NOTE_LOCAL = 2'd1,
        CMD_QUERY      = 2'd2,
        CMD_CLEAR      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REPLACED = 2'd1,
        ST_DROPPED  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RSCAN, S_RWAIT, S_LSCAN, S_LWAIT,
        S_QREAD, S_QRWAIT, S_QLSCAN, S_QLWAIT, S_MOD, S_DONE
    } state_t;

    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        logic [15:0] r;
        r = {1'b0, s[15:1]};
        if (s[0]) r = r ^ LFSR_TAPS;
        return r;
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/peer_bundle_table_select.sv
`default_nettype none
// Peer bundle table with best-bundle selection. One command is handled at a
// time. Memory scans address each slot, then compare it.
// - Peer note: a match at slot k updates that slot; otherwise the entry is
//   appended, or written over a random slot when the table is full.
// - Local note: a match at slot j updates that slot; otherwise the entry is
//   appended, or dropped when the local table is full.
// - Query: reads each peer slot and scans the local table for it.
// - Clear: resets the peer's entry count.
// A finished result moves into the output register, so the next command is
// taken while a result waits. A command that finishes while that register is
// still full waits in its last state. Memories have undefined contents until
// written.
module peer_bundle_table_select
    import pbts_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_command,
    input  wire logic [2:0]        s_peer_index,
    input  wire logic [63:0]       s_bundle_key,
    input  wire logic [62:0]       s_bundle_version,
    input  wire logic [7:0]        s_size_class,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_found,
    output logic [5:0]             m_entry_index,
    output logic [63:0]            m_key_out,
    output logic [62:0]            m_version_out,
    output logic [7:0]             m_size_out,
    output logic [1:0]             m_status
);
    // memories
    logic [KEY_W+VER_W+SIZE_W-1:0] rmem [PEERS*ENTRIES];
    logic [KEY_W+VER_W-1:0]        lmem [LOCAL_BUNDLES];
    logic [KEY_W+VER_W+SIZE_W-1:0] rrd;
    logic [KEY_W+VER_W-1:0]        lrd;
    logic [PEER_W+SLOT_W-1:0]      raddr;
    logic [LADDR_W-1:0]            laddr;
    logic                          rwe, lwe;
    logic [KEY_W+VER_W+SIZE_W-1:0] rwd;
    logic [KEY_W+VER_W-1:0]        lwd;

    always_ff @(posedge aclk) begin
        if (rwe) rmem[raddr] <= rwd;
        rrd <= rmem[raddr];
    end
    always_ff @(posedge aclk) begin
        if (lwe) lmem[laddr] <= lwd;
        lrd <= lmem[laddr];
    end

    state_t state_reg, state_next;
    logic [PEER_W-1:0] peer_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VER_W-1:0] ver_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [CNT_W-1:0] cnt_reg [PEERS];
    logic [LCNT_W-1:0] lcnt_reg;
    logic [15:0] rnd_reg;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [LCNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] cnt_cur;
    // query best
    logic have_reg;
    logic [SLOT_W-1:0] best_reg;
    logic [KEY_W-1:0] bkey_reg;
    logic [VER_W-1:0] bver_reg;
    logic [SIZE_W-1:0] bsize_reg;
    logic [KEY_W+VER_W+SIZE_W-1:0] cand_reg;
    logic [SLOT_W-1:0] rem_reg;
    // working result
    logic o_found;
    logic [5:0] o_idx;
    logic [1:0] o_stat;
    logic o_data;
    // output register
    logic out_load;
    logic res_found_reg;
    logic [5:0] res_idx_reg;
    logic [KEY_W-1:0] res_key_reg;
    logic [VER_W-1:0] res_ver_reg;
    logic [SIZE_W-1:0] res_size_reg;
    logic [1:0] res_stat_reg;

    assign cnt_cur = cnt_reg[peer_reg];
    assign s_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!m_valid || m_ready);

    logic rs_match, ls_match;
    assign rs_match = rrd[KEY_W+VER_W+SIZE_W-1 -: KEY_W] == key_reg;
    assign ls_match = lrd[KEY_W+VER_W-1 -: KEY_W] == key_reg;
    logic qcov;
    assign qcov = (lrd[KEY_W+VER_W-1 -: KEY_W] == cand_reg[KEY_W+VER_W+SIZE_W-1 -: KEY_W])
               && (lrd[VER_W-1:0] >= cand_reg[VER_W+SIZE_W-1 -: VER_W]);
    logic qbetter;
    assign qbetter = !have_reg || (cand_reg[SIZE_W-1:0] < bsize_reg)
        || (cand_reg[SIZE_W-1:0] == bsize_reg
            && cand_reg[VER_W+SIZE_W-1 -: VER_W] < bver_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_valid && s_ready) begin
                if (s_command == CMD_NOTE_LOCAL) state_next = S_LSCAN;
                else if (s_peer_index >= PEER_W'(PEERS - 1) + 1'b0 &&
                         {1'b0, s_peer_index} >= 4'(PEERS)) state_next = S_DONE;
                else if (s_command == CMD_CLEAR) state_next = S_DONE;
                else if (s_command == CMD_NOTE_PEER) state_next = S_RSCAN;
                else state_next = S_QREAD;
            end
            S_RSCAN: state_next = (i_reg < cnt_cur) ? S_RWAIT :
                                  (cnt_cur == CNT_W'(ENTRIES)) ? S_MOD : S_DONE;
            S_RWAIT: state_next = rs_match ? S_DONE : S_RSCAN;
            S_MOD:   state_next = S_DONE;
            S_LSCAN: state_next = (j_reg < lcnt_reg) ? S_LWAIT : S_DONE;
            S_LWAIT: state_next = ls_match ? S_DONE : S_LSCAN;
            S_QREAD: state_next = (i_reg < cnt_cur) ? S_QRWAIT : S_DONE;
            S_QRWAIT: state_next = S_QLSCAN;
            S_QLSCAN: state_next = (j_reg < lcnt_reg) ? S_QLWAIT : S_QREAD;
            S_QLWAIT: state_next = qcov ? S_QREAD : S_QLSCAN;
            S_DONE:  state_next = out_load ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // memory control
    always_comb begin
        raddr = {peer_reg, i_reg[SLOT_W-1:0]};
        laddr = j_reg[LADDR_W-1:0];
        rwe = 1'b0;
        lwe = 1'b0;
        rwd = {key_reg, ver_reg, size_reg};
        lwd = {key_reg, ver_reg};
        i_next = i_reg;
        j_next = j_reg;
        case (state_reg)
            S_IDLE: begin
                i_next = '0;
                j_next = '0;
            end
            S_RSCAN: begin
                if (i_reg < cnt_cur) i_next = i_reg + 1'b1;
                else if (cnt_cur != CNT_W'(ENTRIES)) rwe = 1'b1;
            end
            S_RWAIT: if (rs_match) begin
                raddr = {peer_reg, 6'(i_reg - 1'b1)};
                rwe = 1'b1;
            end
            S_MOD: begin
                raddr = {peer_reg, rem_reg};
                rwe = 1'b1;
            end
            S_LSCAN: begin
                if (j_reg < lcnt_reg) j_next = j_reg + 1'b1;
                else if (lcnt_reg != LCNT_W'(LOCAL_BUNDLES)) lwe = 1'b1;
            end
            S_LWAIT: if (ls_match) begin
                laddr = LADDR_W'(j_reg - 1'b1);
                lwe = 1'b1;
            end
            S_QREAD: begin
                j_next = '0;
                if (i_reg < cnt_cur) i_next = i_reg + 1'b1;
            end
            S_QLSCAN: if (j_reg < lcnt_reg) j_next = j_reg + 1'b1;
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            lcnt_reg <= '0;
            rnd_reg <= SEED_RESET;
            m_valid <= 1'b0;
            for (int p = 0; p < PEERS; p++) cnt_reg[p] <= '0;
        end else begin
            state_reg <= state_next;
            i_reg <= i_next;
            j_reg <= j_next;
            // seed load, or one generator step for each random replacement
            if (cfg_we) rnd_reg <= (cfg_wdata == 16'd0) ? SEED_RESET : cfg_wdata;
            else if (state_reg == S_RSCAN && i_reg >= cnt_cur
                     && cnt_cur == CNT_W'(ENTRIES))
                rnd_reg <= lfsr_next(rnd_reg);
            // result transfer and output register load
            if (out_load) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            if (out_load) begin
                res_found_reg <= o_found;
                res_idx_reg <= o_idx;
                res_stat_reg <= o_stat;
                res_key_reg <= o_data ? bkey_reg : '0;
                res_ver_reg <= o_data ? bver_reg : '0;
                res_size_reg <= o_data ? bsize_reg : '0;
            end
            case (state_reg)
                S_IDLE: if (s_valid && s_ready) begin
                    peer_reg <= s_peer_index;
                    key_reg <= s_bundle_key;
                    ver_reg <= s_bundle_version;
                    size_reg <= s_size_class;
                    o_found <= 1'b0;
                    o_idx <= '0;
                    o_stat <= ST_OK;
                    o_data <= 1'b0;
                    have_reg <= 1'b0;
                    if (s_command == CMD_CLEAR && {1'b0, s_peer_index} < 4'(PEERS))
                        cnt_reg[s_peer_index] <= '0;
                end
                // full table: victim is the new generator state modulo the
                // slot count, a power of two, so its low bits
                S_RSCAN: if (i_reg >= cnt_cur) begin
                    if (cnt_cur == CNT_W'(ENTRIES)) begin
                        rem_reg <= SLOT_W'(lfsr_next(rnd_reg));
                        o_stat <= ST_REPLACED;
                    end else begin
                        o_idx <= i_reg[SLOT_W-1:0];
                        cnt_reg[peer_reg] <= cnt_cur + 1'b1;
                    end
                end
                S_RWAIT: if (rs_match) begin
                    o_found <= 1'b1;
                    o_idx <= 6'(i_reg - 1'b1);
                end
                S_MOD: o_idx <= rem_reg;
                S_LSCAN: if (j_reg >= lcnt_reg) begin
                    if (lcnt_reg == LCNT_W'(LOCAL_BUNDLES)) o_stat <= ST_DROPPED;
                    else begin
                        o_idx <= j_reg[SLOT_W-1:0];
                        lcnt_reg <= lcnt_reg + 1'b1;
                    end
                end
                S_LWAIT: if (ls_match) begin
                    o_found <= 1'b1;
                    o_idx <= 6'(j_reg - 1'b1);
                end
                S_QRWAIT: cand_reg <= rrd;
                S_QLSCAN: if (j_reg >= lcnt_reg && qbetter) begin
                    have_reg <= 1'b1;
                    best_reg <= 6'(i_reg - 1'b1);
                    bkey_reg <= cand_reg[KEY_W+VER_W+SIZE_W-1 -: KEY_W];
                    bver_reg <= cand_reg[VER_W+SIZE_W-1 -: VER_W];
                    bsize_reg <= cand_reg[SIZE_W-1:0];
                end
                S_QREAD: if (i_reg >= cnt_cur && have_reg) begin
                    o_found <= 1'b1;
                    o_idx <= best_reg;
                    o_data <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign m_found = res_found_reg;
    assign m_entry_index = res_idx_reg;
    assign m_status = res_stat_reg;
    assign m_key_out = res_key_reg;
    assign m_version_out = res_ver_reg;
    assign m_size_out = res_size_reg;
endmodule
`default_nettype wire

>>> rtl/core/pbts_checker.sv
`default_nettype none
module pbts_sva
    import pbts_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_found,
    input wire logic [1:0] m_status,
    input wire logic [63:0] m_key_out
);
    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    // a stalled result keeps its payload
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable({m_found, m_status, m_key_out}))
        else $error("result changed while stalled");
    // one command at a time
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("input taken while busy");
    // status code in range
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_DROPPED) else $error("bad status");
    // a key is only shown when found
    a_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_key_out == 64'd0) else $error("stray key");
endmodule

bind peer_bundle_table_select pbts_sva u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_found(m_found),
    .m_status(m_status), .m_key_out(m_key_out)
);
`default_nettype wire

>>> tb/sv/pbts_checker.sv
module pbts_checker
    import pbts_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [2:0]  s_peer_index,
    input  wire logic [63:0] s_bundle_key,
    input  wire logic [62:0] s_bundle_version,
    input  wire logic [7:0]  s_size_class,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_found,
    input  wire logic [5:0]  m_entry_index,
    input  wire logic [63:0] m_key_out,
    input  wire logic [62:0] m_version_out,
    input  wire logic [7:0]  m_size_out,
    input  wire logic [1:0]  m_status,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        found;
        logic [5:0]  idx;
        logic [63:0] key;
        logic [62:0] ver;
        logic [7:0]  size;
        status_t     status;
    } answer_t;

    // shadow of the tables
    logic [63:0] peer_keys  [PEERS][ENTRIES];
    logic [62:0] peer_vers  [PEERS][ENTRIES];
    logic [7:0]  peer_sizes [PEERS][ENTRIES];
    int          peer_fill  [PEERS];
    logic [63:0] held_keys  [LOCAL_BUNDLES];
    logic [62:0] held_vers  [LOCAL_BUNDLES];
    int          held_fill;
    logic [15:0] victim_lfsr;
    answer_t     answers_due [$];

    function automatic bit held_newer(logic [63:0] k, logic [62:0] v);
        for (int i = 0; i < held_fill; i++)
            if (held_keys[i] == k && held_vers[i] >= v) return 1;
        return 0;
    endfunction

    // apply one command to the shadow tables and return its answer
    function automatic answer_t table_update(cmd_t c, int p, logic [63:0] k,
                                             logic [62:0] v, logic [7:0] sz);
        answer_t a;
        int slot;
        int best;
        a = '0;
        a.status = ST_OK;
        case (c)
            CMD_NOTE_LOCAL: begin
                for (int i = 0; i < held_fill; i++)
                    if (held_keys[i] == k) begin
                        held_vers[i] = v;
                        a.found = 1;
                        a.idx = i[5:0];
                        return a;
                    end
                if (held_fill >= LOCAL_BUNDLES) begin
                    a.status = ST_DROPPED;
                    return a;
                end
                held_keys[held_fill] = k;
                held_vers[held_fill] = v;
                a.idx = held_fill[5:0];
                held_fill++;
            end
            CMD_CLEAR: peer_fill[p] = 0;
            CMD_NOTE_PEER: begin
                for (int i = 0; i < peer_fill[p]; i++)
                    if (peer_keys[p][i] == k) begin
                        peer_vers[p][i] = v;
                        peer_sizes[p][i] = sz;
                        a.found = 1;
                        a.idx = i[5:0];
                        return a;
                    end
                if (peer_fill[p] >= ENTRIES) begin
                    victim_lfsr = {1'b0, victim_lfsr[15:1]}
                                  ^ (victim_lfsr[0] ? 16'hB400 : 16'h0);
                    slot = int'(victim_lfsr) % peer_fill[p];
                    a.status = ST_REPLACED;
                end else begin
                    slot = peer_fill[p];
                    peer_fill[p]++;
                end
                peer_keys[p][slot] = k;
                peer_vers[p][slot] = v;
                peer_sizes[p][slot] = sz;
                a.idx = slot[5:0];
            end
            default: begin
                best = -1;
                for (int i = 0; i < peer_fill[p]; i++) begin
                    if (held_newer(peer_keys[p][i], peer_vers[p][i])) continue;
                    if (best < 0 || peer_sizes[p][i] < peer_sizes[p][best]
                        || (peer_sizes[p][i] == peer_sizes[p][best]
                            && peer_vers[p][i] < peer_vers[p][best]))
                        best = i;
                end
                if (best >= 0) begin
                    a.found = 1;
                    a.idx = best[5:0];
                    a.key = peer_keys[p][best];
                    a.ver = peer_vers[p][best];
                    a.size = peer_sizes[p][best];
                end
            end
        endcase
        return a;
    endfunction

    always @(posedge aclk) begin
        answer_t want;
        answer_t got;
        if (!aresetn) begin
            for (int i = 0; i < PEERS; i++) peer_fill[i] = 0;
            held_fill = 0;
            victim_lfsr = SEED_RESET;
            answers_due.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (cfg_we) victim_lfsr = (cfg_wdata == 16'd0) ? SEED_RESET : cfg_wdata;
            // result transfer compared before the new input is predicted
            if (m_valid && m_ready) begin
                got = '{m_found, m_entry_index, m_key_out, m_version_out,
                        m_size_out, status_t'(m_status)};
                if (answers_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %p", got);
                end else begin
                    want = answers_due.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (s_valid && s_ready)
                answers_due.push_back(table_update(cmd_t'(s_command),
                    int'(s_peer_index), s_bundle_key, s_bundle_version,
                    s_size_class));
            pending = answers_due.size();
        end
    end
endmodule

>>> tb/sv/tb_peer_bundle_table_select.sv
module tb_peer_bundle_table_select
    import pbts_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 200000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [2:0]  s_peer_index;
    logic [63:0] s_bundle_key;
    logic [62:0] s_bundle_version;
    logic [7:0]  s_size_class;
    logic        m_valid;
    logic        m_ready;
    logic        m_found;
    logic [5:0]  m_entry_index;
    logic [63:0] m_key_out;
    logic [62:0] m_version_out;
    logic [7:0]  m_size_out;
    logic [1:0]  m_status;
    int          fail_count;
    int          pending;
    bit          hold_off;
    int          idle_cycles;
    logic [63:0] key_pool [16];

    peer_bundle_table_select DUT (.*);
    pbts_checker u_checker (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver with random stalls and one long hold-off
    initial begin
        int gap;
        m_ready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 0;
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk iff m_valid);
        end
    end

    task automatic send_cmd(cmd_t c, logic [2:0] p, logic [63:0] k,
                            logic [62:0] v, logic [7:0] sz, bit pause);
        int gap;
        gap = pause ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_command <= c;
        s_peer_index <= p;
        s_bundle_key <= k;
        s_bundle_version <= v;
        s_size_class <= sz;
        @(posedge aclk iff s_ready);
    endtask

    task automatic drain_then_seed(logic [15:0] seed);
        s_valid <= 0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (30000) @(posedge aclk);
        cfg_we <= 1;
        cfg_wdata <= seed;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic random_cmd(bit pause);
        cmd_t c;
        int r;
        logic [63:0] k;
        r = $urandom_range(0, 99);
        c = r < 60 ? CMD_NOTE_PEER : r < 80 ? CMD_NOTE_LOCAL
          : r < 95 ? CMD_QUERY : CMD_CLEAR;
        k = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
          : key_pool[$urandom_range(0, 15)];
        send_cmd(c, $urandom_range(0, 1) ? 3'($urandom_range(0, 1)) : 3'($urandom),
                 k, 63'({$urandom, $urandom} >> $urandom_range(0, 60)),
                 8'($urandom), pause);
    endtask

    initial begin
        hold_off = 0;
        aresetn = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        s_valid = 0;
        s_command = CMD_NOTE_PEER;
        s_peer_index = 0;
        s_bundle_key = 0;
        s_bundle_version = 0;
        s_size_class = 0;
        for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, every command, matches and covered entries
        send_cmd(CMD_QUERY, 3'd7, 0, 0, 0, 0);
        send_cmd(CMD_NOTE_PEER, 3'd7, '1, '1, 8'hFF, 0);
        send_cmd(CMD_NOTE_PEER, 3'd7, 64'd0, 63'd0, 8'h00, 0);
        send_cmd(CMD_NOTE_PEER, 3'd7, 64'd5, 63'd9, 8'h00, 0);
        send_cmd(CMD_QUERY, 3'd7, 0, 0, 0, 0);
        send_cmd(CMD_NOTE_LOCAL, 3'd0, 64'd0, 63'd0, 0, 0);
        send_cmd(CMD_QUERY, 3'd7, 0, 0, 0, 0);
        send_cmd(CMD_NOTE_LOCAL, 3'd0, 64'd5, 63'd3, 0, 0);
        send_cmd(CMD_QUERY, 3'd7, 0, 0, 0, 0);
        send_cmd(CMD_NOTE_LOCAL, 3'd0, 64'd5, 63'd9, 0, 0);
        send_cmd(CMD_NOTE_PEER, 3'd7, '1, 63'd1, 8'hFF, 0);
        send_cmd(CMD_QUERY, 3'd7, 0, 0, 0, 0);
        send_cmd(CMD_CLEAR, 3'd7, 0, 0, 0, 0);
        send_cmd(CMD_QUERY, 3'd7, 0, 0, 0, 0);

        // fill peer 2 past capacity, starting while the receiver holds off
        hold_off = 1;
        for (int i = 0; i < 72; i++)
            send_cmd(CMD_NOTE_PEER, 3'd2, 64'(1000 + i), 63'(i), 8'($urandom), 0);
        send_cmd(CMD_QUERY, 3'd2, 0, 0, 0, 0);

        drain_then_seed(16'd0);
        for (int i = 0; i < 20; i++)
            send_cmd(CMD_NOTE_PEER, 3'd2, 64'(5000 + i), '1, 8'd1, 1);
        drain_then_seed(16'hFFFF);
        for (int i = 0; i < 20; i++)
            send_cmd(CMD_NOTE_PEER, 3'd2, 64'(6000 + i), 0, 8'd1, 1);
        drain_then_seed(16'd1);

        // random traffic, some stretches without gaps
        for (int n = 0; n < 1600; n++) begin
            random_cmd((n / 100) % 3 != 0);
            if (n == 800) drain_then_seed(16'($urandom_range(1, 65535)));
        end

        // overflow the local table, then more random traffic
        for (int i = 0; i < 260; i++)
            send_cmd(CMD_NOTE_LOCAL, 3'd0, {$urandom, $urandom}, 63'(i), 0, 0);
        for (int n = 0; n < 40; n++) random_cmd(1);

        s_valid <= 0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
